// ===== rtl/msmp_pkg.sv =====
package msmp_pkg;

  localparam int MAX_WINDOWS = 8;
  localparam int MAX_BANDS   = 64;
  localparam int WCOUNT_W    = $clog2(MAX_WINDOWS + 1);
  localparam int WIN_W       = $clog2(MAX_WINDOWS);
  localparam int BAND_W      = 6;

  // cmd field of an input word
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_BIT   = 1'b1;

  // status field of a result word
  localparam logic [1:0] STAT_NO_MS  = 2'd0;
  localparam logic [1:0] STAT_MASK   = 2'd1;
  localparam logic [1:0] STAT_ALL    = 2'd2;
  localparam logic [1:0] STAT_ERROR  = 2'd3;

  // two-bit presence code from the bitstream
  localparam logic [1:0] PRES_NONE = 2'd0;
  localparam logic [1:0] PRES_MASK = 2'd1;
  localparam logic [1:0] PRES_ALL  = 2'd2;

  typedef struct packed {
    logic                   cmd;
    logic                   stream_bit;
    logic [3:0]             num_windows;
    logic [BAND_W-1:0]      bands_per_window;
    logic [BAND_W-1:0]      max_bands;
    logic [MAX_WINDOWS-1:0] group_starts;
  } msmp_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [WIN_W-1:0]     group_index;
    logic [MAX_BANDS-1:0] mask_row;
    logic [BAND_W-1:0]    band_count;
    logic                 last;
  } msmp_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRESENT,
    ST_MASK,
    ST_BURST
  } msmp_state_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_NO_MS,
    EM_ERROR,
    EM_ROW,
    EM_BURST
  } msmp_emit_t;

  typedef struct packed {
    logic       load_frame;
    logic       pos_clear;
    logic       burst_load;
    logic       burst_all;
    logic       shift_bit;
    logic       advance;
    msmp_emit_t emit;
  } msmp_cmd_t;

  typedef struct packed {
    logic active_over;
    logic active_zero;
    logic row_done;
    logic last_group;
    logic out_busy;
  } msmp_stat_t;

endpackage

// ===== rtl/msmp_dpath.sv =====
module msmp_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  msmp_pkg::msmp_item_t  item,
  input  msmp_pkg::msmp_cmd_t   cmd,
  output msmp_pkg::msmp_stat_t  stat,
  output msmp_pkg::msmp_result_t result,
  output logic                  result_valid,
  input  logic                  result_stall
);
  import msmp_pkg::*;

  logic [BAND_W-1:0]      bands_latched;
  logic [BAND_W-1:0]      active_latched;
  logic [MAX_WINDOWS-1:0] group_map;
  logic [WIN_W-1:0]       window_pos;
  logic [WIN_W-1:0]       group_pos;
  logic [BAND_W-1:0]      bit_pos;
  logic [MAX_BANDS-1:0]   row_shift;
  logic                   burst_all;

  logic [WCOUNT_W-1:0]    wc_clamp;
  logic [MAX_WINDOWS-1:0] map_new;
  logic [WCOUNT_W-1:0]    search_from;
  logic                   start_found;
  logic [WIN_W-1:0]       next_window;
  logic [MAX_BANDS-1:0]   row_new;
  logic [MAX_BANDS-1:0]   all_ones;
  logic [BAND_W-1:0]      bit_inc;
  msmp_result_t           result_next;

  // clamp window count into 1..MAX_WINDOWS and mask the group bitmap
  always_comb begin
    if (item.num_windows == 4'd0) begin
      wc_clamp = WCOUNT_W'(1);
    end else if (item.num_windows > 4'(MAX_WINDOWS)) begin
      wc_clamp = WCOUNT_W'(MAX_WINDOWS);
    end else begin
      wc_clamp = WCOUNT_W'(item.num_windows);
    end
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      map_new[i] = ((i == 0) ? 1'b1 : item.group_starts[i]) &&
                   (WCOUNT_W'(i) < wc_clamp);
    end
  end

  // lowest group start after the current window
  always_comb begin
    search_from = WCOUNT_W'(window_pos) + WCOUNT_W'(1);
    start_found = 1'b0;
    next_window = '0;
    for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
      if (group_map[i] && (WCOUNT_W'(i) >= search_from)) begin
        start_found = 1'b1;
        next_window = WIN_W'(i);
      end
    end
  end

  assign bit_inc  = bit_pos + BAND_W'(1);
  assign row_new  = row_shift | (MAX_BANDS'(item.stream_bit) << bit_pos);
  assign all_ones = ~({MAX_BANDS{1'b1}} << bands_latched);

  assign stat.active_over = active_latched > bands_latched;
  assign stat.active_zero = active_latched == '0;
  assign stat.row_done    = bit_inc == active_latched;
  assign stat.last_group  = !start_found;
  assign stat.out_busy    = result_valid && result_stall;

  always_comb begin
    result_next             = result;
    result_next.group_index = group_pos;
    result_next.band_count  = bands_latched;
    result_next.last        = !start_found;
    case (cmd.emit)
      EM_NO_MS, EM_ERROR: begin
        result_next.status      = (cmd.emit == EM_ERROR) ? STAT_ERROR : STAT_NO_MS;
        result_next.group_index = '0;
        result_next.mask_row    = '0;
        result_next.band_count  = '0;
        result_next.last        = 1'b1;
      end
      EM_ROW: begin
        result_next.status   = STAT_MASK;
        result_next.mask_row = row_new;
      end
      EM_BURST: begin
        result_next.status   = burst_all ? STAT_ALL : STAT_MASK;
        result_next.mask_row = burst_all ? all_ones : '0;
      end
      default: begin
        result_next = result;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid   <= 1'b0;
      bands_latched  <= '0;
      active_latched <= '0;
      group_map      <= MAX_WINDOWS'(1);
      window_pos     <= '0;
      group_pos      <= '0;
      bit_pos        <= '0;
      burst_all      <= 1'b0;
    end else begin
      if (cmd.emit != EM_NONE) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cmd.load_frame) begin
        bands_latched  <= item.bands_per_window;
        active_latched <= item.max_bands;
        group_map      <= map_new;
      end
      if (cmd.load_frame || cmd.pos_clear) begin
        window_pos <= '0;
        group_pos  <= '0;
        bit_pos    <= '0;
      end else if (cmd.advance) begin
        window_pos <= next_window;
        group_pos  <= group_pos + WIN_W'(1);
        bit_pos    <= '0;
      end else if (cmd.shift_bit) begin
        bit_pos <= bit_inc;
      end
      if (cmd.burst_load) begin
        burst_all <= cmd.burst_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      result <= result_next;
    end
    if (cmd.load_frame || cmd.pos_clear || cmd.advance) begin
      row_shift <= '0;
    end else if (cmd.shift_bit) begin
      row_shift <= row_new;
    end
  end

endmodule

// ===== rtl/msmp_ctrl.sv =====
module msmp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  msmp_pkg::msmp_item_t item,
  input  logic                 item_valid,
  output logic                 item_stall,
  output msmp_pkg::msmp_cmd_t  cmd,
  input  msmp_pkg::msmp_stat_t stat
);
  import msmp_pkg::*;

  msmp_state_t state, state_next;
  logic        pres_seen, pres_seen_next;
  logic        pres_hi, pres_hi_next;
  logic        ready;
  logic        take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pres_seen <= 1'b0;
      pres_hi   <= 1'b0;
    end else begin
      state     <= state_next;
      pres_seen <= pres_seen_next;
      pres_hi   <= pres_hi_next;
    end
  end

  assign ready      = (state != ST_BURST) && !stat.out_busy;
  assign item_stall = !ready;
  assign take       = item_valid && ready;

  always_comb begin
    state_next     = state;
    pres_seen_next = pres_seen;
    pres_hi_next   = pres_hi;
    cmd            = '0;
    cmd.emit       = EM_NONE;
    if (take) begin
      if (item.cmd == CMD_FRAME) begin
        cmd.load_frame = 1'b1;
        state_next     = ST_PRESENT;
        pres_seen_next = 1'b0;
      end else begin
        case (state)
          ST_PRESENT: begin
            if (!pres_seen) begin
              pres_seen_next = 1'b1;
              pres_hi_next   = item.stream_bit;
            end else begin
              pres_seen_next = 1'b0;
              state_next     = ST_IDLE;
              case ({pres_hi, item.stream_bit})
                PRES_NONE: begin
                  cmd.emit = EM_NO_MS;
                end
                PRES_ALL: begin
                  cmd.burst_load = 1'b1;
                  cmd.burst_all  = 1'b1;
                  cmd.pos_clear  = 1'b1;
                  state_next     = ST_BURST;
                end
                PRES_MASK: begin
                  if (stat.active_over) begin
                    cmd.emit = EM_ERROR;
                  end else if (stat.active_zero) begin
                    cmd.burst_load = 1'b1;
                    cmd.pos_clear  = 1'b1;
                    state_next     = ST_BURST;
                  end else begin
                    cmd.pos_clear = 1'b1;
                    state_next    = ST_MASK;
                  end
                end
                default: begin
                  cmd.emit = EM_ERROR;
                end
              endcase
            end
          end
          ST_MASK: begin
            cmd.shift_bit = 1'b1;
            if (stat.row_done) begin
              cmd.emit = EM_ROW;
              if (stat.last_group) begin
                cmd.pos_clear = 1'b1;
                state_next    = ST_IDLE;
              end else begin
                cmd.advance = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end else if (state == ST_BURST && !stat.out_busy) begin
      cmd.emit = EM_BURST;
      if (stat.last_group) begin
        cmd.pos_clear = 1'b1;
        state_next    = ST_IDLE;
      end else begin
        cmd.advance = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ms_mask_parser_core.sv =====
// Mid/side mask parser. Feed a frame-start word (cmd 0) with the frame's
// window count, bands per window, active band count and group-start bitmap,
// then the bitstream one bit per word (cmd 1). The block reads the two
// presence bits, then either returns one "no mid/side" result, one error,
// or one mask row per window group; the final result of a frame has last
// set. Bit words that arrive outside a frame are dropped without a result,
// and a new frame-start word abandons the running frame. Throughput is one
// input word per cycle while the result register is free: each word is
// consumed in the cycle it is accepted and a row leaves through a single
// result register, so a stalled result holds the input off. Presence code 2,
// or code 1 with zero active bands, produces one row per group from the
// controller's burst state, one row per cycle while the result is not held;
// input is stalled throughout the burst.
module ms_mask_parser_core (
  input  logic                   clk,
  input  logic                   rst,
  input  msmp_pkg::msmp_item_t   item,
  input  logic                   item_valid,
  output logic                   item_stall,
  output msmp_pkg::msmp_result_t result,
  output logic                   result_valid,
  input  logic                   result_stall
);
  import msmp_pkg::*;

  msmp_cmd_t  cmd;
  msmp_stat_t stat;

  // controller: presence decode and burst sequencing
  msmp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  // datapath: frame registers, row shifter, group walk, result register
  msmp_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // a held result must keep new words out
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> item_stall)
    else $error("input accepted while result is held");

  // terminal results carry no row and end the frame
  a_terminal_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status == STAT_NO_MS || result.status == STAT_ERROR))
      |-> (result.last && result.mask_row == '0 && result.band_count == '0 &&
           result.group_index == '0))
    else $error("no mid/side or error result malformed");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

// ===== tb/sv/ms_mask_parser_core_check.sv =====
`timescale 1ns / 100ps

module ms_mask_parser_core_check (
  input  logic                   clk,
  input  logic                   rst,
  input  msmp_pkg::msmp_item_t   item,
  input  logic                   item_valid,
  input  logic                   item_stall,
  input  msmp_pkg::msmp_result_t result,
  input  logic                   result_valid,
  input  logic                   result_stall,
  output int                     failures,
  output int                     outstanding
);
  import msmp_pkg::*;

  // predicted parser state
  msmp_state_t  phase_q;
  logic [1:0]   code_q;
  int unsigned  code_bits;
  logic [3:0]   win_count;
  logic [5:0]   band_num;
  logic [5:0]   active_num;
  logic [7:0]   gmap;
  logic [3:0]   win_pos;
  logic [2:0]   grp;
  logic [5:0]   bit_idx;
  logic [63:0]  row_acc;

  msmp_result_t expected_rows[$];
  msmp_result_t want;
  int           fail_count;
  logic         bad;

  initial begin
    failures    = 0;
    outstanding = 0;
    fail_count  = 0;
  end

  // first window at or after from that opens a group, else the window count
  function automatic logic [3:0] next_group_start(input logic [3:0] from);
    for (int w = from; w < win_count && w < MAX_WINDOWS; w++) begin
      if (gmap[w]) return 4'(w);
    end
    return win_count;
  endfunction

  task automatic push_row(input logic [1:0] st, input logic [2:0] g, input logic [63:0] row,
                          input logic [5:0] cnt, input logic lst);
    msmp_result_t r;
    r.status      = st;
    r.group_index = g;
    r.mask_row    = row;
    r.band_count  = cnt;
    r.last        = lst;
    expected_rows.push_back(r);
  endtask

  // one fixed row per group of the frame
  task automatic emit_groups(input logic [1:0] st, input logic [63:0] row);
    logic [3:0] w;
    logic [3:0] nw;
    logic [2:0] g;
    w = '0;
    g = '0;
    while (w < win_count) begin
      nw = next_group_start(w + 4'd1);
      push_row(st, g, row, band_num, nw >= win_count);
      g = g + 3'd1;
      w = nw;
    end
  endtask

  task automatic parse_word(input msmp_item_t w);
    logic [3:0] nwin;
    logic [3:0] nxt;
    logic       lst;
    if (w.cmd == CMD_FRAME) begin
      nwin = w.num_windows;
      if (nwin == 4'd0) nwin = 4'd1;
      if (nwin > MAX_WINDOWS) nwin = 4'(MAX_WINDOWS);
      win_count  = nwin;
      band_num   = w.bands_per_window;  // six bits never exceed MAX_BANDS
      active_num = w.max_bands;
      gmap       = w.group_starts | 8'd1;
      phase_q    = ST_PRESENT;
      code_q     = '0;
      code_bits  = 0;
      win_pos    = '0;
      grp        = '0;
      bit_idx    = '0;
      row_acc    = '0;
    end else if (phase_q == ST_PRESENT) begin
      code_q    = {code_q[0], w.stream_bit};
      code_bits = code_bits + 1;
      if (code_bits == 2) begin
        code_bits = 0;
        phase_q   = ST_IDLE;
        case (code_q)
          PRES_NONE: push_row(STAT_NO_MS, '0, '0, '0, 1'b1);
          PRES_ALL:  emit_groups(STAT_ALL, (64'd1 << band_num) - 64'd1);
          PRES_MASK: begin
            if (active_num > band_num) begin
              push_row(STAT_ERROR, '0, '0, '0, 1'b1);
            end else if (active_num == '0) begin
              emit_groups(STAT_MASK, '0);
            end else begin
              phase_q = ST_MASK;
              win_pos = '0;
              grp     = '0;
              bit_idx = '0;
              row_acc = '0;
            end
          end
          default: push_row(STAT_ERROR, '0, '0, '0, 1'b1);
        endcase
      end
    end else if (phase_q == ST_MASK) begin
      row_acc = row_acc | (64'(w.stream_bit) << bit_idx);
      bit_idx = bit_idx + 6'd1;
      if (bit_idx == active_num) begin
        nxt = next_group_start(win_pos + 4'd1);
        lst = nxt >= win_count;
        push_row(STAT_MASK, grp, row_acc, band_num, lst);
        row_acc = '0;
        bit_idx = '0;
        if (lst) begin
          phase_q = ST_IDLE;
          win_pos = '0;
          grp     = '0;
        end else begin
          win_pos = nxt;
          grp     = grp + 3'd1;
        end
      end
    end
    // bits outside a frame fall through: no state change
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase_q    = ST_IDLE;
      code_q     = '0;
      code_bits  = 0;
      win_count  = 4'd1;
      band_num   = '0;
      active_num = '0;
      gmap       = 8'd1;
      win_pos    = '0;
      grp        = '0;
      bit_idx    = '0;
      row_acc    = '0;
      expected_rows.delete();
    end else begin
      if (item_valid && !item_stall) parse_word(item);
      if (result_valid && !result_stall) begin
        if (expected_rows.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("%0t: unexpected result: status %0d group %0d mask %h bands %0d last %0d",
                     $time, result.status, result.group_index, result.mask_row,
                     result.band_count, result.last);
        end else begin
          want = expected_rows.pop_front();
          bad  = (result.status !== want.status) || (result.group_index !== want.group_index) ||
                 (result.mask_row !== want.mask_row) ||
                 (result.band_count !== want.band_count) || (result.last !== want.last);
          if (bad) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected: status %0d group %0d mask %h bands %0d last %0d",
                       want.status, want.group_index, want.mask_row, want.band_count,
                       want.last);
              $display("  actual:   status %0d group %0d mask %h bands %0d last %0d",
                       result.status, result.group_index, result.mask_row,
                       result.band_count, result.last);
            end
          end
        end
      end
    end
    failures    <= fail_count;
    outstanding <= expected_rows.size();
  end

endmodule

// ===== tb/sv/ms_mask_parser_core_test.sv =====
`timescale 1ns / 100ps

module ms_mask_parser_core_test;
  import msmp_pkg::*;

  // receiver stall behaviors, switched after random stretches
  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_HEAVY,
    RX_BEAT
  } rx_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  msmp_item_t   item = '0;
  logic         item_valid = 1'b0;
  logic         item_stall;
  msmp_result_t result;
  logic         result_valid;
  logic         result_stall = 1'b0;

  int           failures;
  int           outstanding;
  int           burst_left = 0;
  int           words_sent = 0;

  rx_mode_t     rx_mode = RX_FREE;
  int           rx_left = 0;

  ms_mask_parser_core uut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  ms_mask_parser_core_check mask_check (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: hold one stall behavior for a random stretch, then pick another.
  // RX_FREE gives stretches with no back-pressure at all.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 60);
    end else begin
      rx_left = rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  result_stall <= 1'b0;
      RX_COIN:  result_stall <= ($urandom_range(0, 1) == 1);
      RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default:  result_stall <= (rx_left % 3 == 0);
    endcase
  end

  // Send one word. The sender works in bursts: at the end of a burst drop
  // valid for a random gap, then start a new burst of random length. Hold the
  // payload until the word is taken.
  task automatic send_word(input msmp_item_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    item       <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    burst_left = burst_left - 1;
    words_sent = words_sent + 1;
  endtask

  // Hold input off until every predicted result has come out.
  task automatic drain_results();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Frame-start word; the unused stream bit is random.
  function automatic msmp_item_t frame_word(input int nw, input int bpw, input int mb,
                                            input int gs);
    msmp_item_t w;
    w.cmd              = CMD_FRAME;
    w.stream_bit       = 1'($urandom_range(0, 1));
    w.num_windows      = 4'(nw);
    w.bands_per_window = 6'(bpw);
    w.max_bands        = 6'(mb);
    w.group_starts     = 8'(gs);
    return w;
  endfunction

  // Bitstream word; frame parameters are don't-care and randomized.
  function automatic msmp_item_t bit_word(input logic b);
    msmp_item_t w;
    w.cmd        = CMD_BIT;
    w.stream_bit = b;
    {w.num_windows, w.bands_per_window, w.max_bands, w.group_starts} = 24'($urandom);
    return w;
  endfunction

  // Send the low n bits of v, most significant first.
  task automatic send_bits(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) send_word(bit_word(v[i]));
  endtask

  // One random frame. Most are well formed with random mask content; some
  // get stray bits ahead of them or are cut short so the next frame start
  // abandons them. A few are wide single-group frames near the band limit.
  task automatic random_frame();
    int         kind;
    int         nw;
    int         bpw;
    int         mb;
    int         gs;
    int         wc;
    int         groups;
    int         total;
    logic [1:0] code;
    logic       cut;
    kind = $urandom_range(0, 99);
    gs   = $urandom_range(0, 255);
    if (kind < 6) begin
      nw   = 1;
      bpw  = $urandom_range(48, 63);
      mb   = $urandom_range(40, bpw);
      code = PRES_MASK;
    end else begin
      if ($urandom_range(0, 3) == 0) nw = $urandom_range(0, 15);
      else nw = $urandom_range(0, 1) ? MAX_WINDOWS : 1;
      bpw = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0:       mb = $urandom_range(0, 63);
        1:       mb = 0;
        default: mb = (bpw == 0) ? 0 : $urandom_range(1, (bpw < 8) ? bpw : 8);
      endcase
      case ($urandom_range(0, 19))
        0, 1:    code = PRES_NONE;
        2, 3, 4: code = PRES_ALL;
        5:       code = 2'b11;
        default: code = PRES_MASK;
      endcase
    end
    cut = ($urandom_range(0, 11) == 0);

    // stray bits: dropped when the parser is idle
    if ($urandom_range(0, 7) == 0) send_bits(64'($urandom), $urandom_range(1, 3));

    send_word(frame_word(nw, bpw, mb, gs));
    if (cut && $urandom_range(0, 1)) begin
      send_bits(64'(code[1]), 1);
      return;
    end
    send_bits(64'(code), 2);

    if (code == PRES_MASK && mb != 0 && mb <= bpw) begin
      wc     = (nw == 0) ? 1 : (nw > MAX_WINDOWS) ? MAX_WINDOWS : nw;
      groups = 0;
      for (int i = 0; i < wc; i++) begin
        if (((gs | 1) >> i) & 1) groups++;
      end
      total = groups * mb;
      if (cut) total = $urandom_range(0, total - 1);
      for (int i = 0; i < total; i++) send_word(bit_word(1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // bit word with no frame open: dropped
    send_word(bit_word(1'b1));
    // zero windows counts as one; presence 0: single no-mid/side result
    send_word(frame_word(0, 0, 0, 0));
    send_bits(64'b00, 2);
    // window count saturates to 8, every window its own group, widest rows
    send_word(frame_word(15, 63, 0, 255));
    send_bits(64'b10, 2);
    // more active bands than bands per window: error
    send_word(frame_word(8, 20, 63, 0));
    send_bits(64'b01, 2);
    // presence 3: error
    send_word(frame_word(4, 10, 2, 8'hAA));
    send_bits(64'b11, 2);
    // zero active bands: all-zero rows at once, two groups
    send_word(frame_word(8, 5, 0, 8'h11));
    send_bits(64'b01, 2);
    // abandon a frame after one presence bit, then parse a two-group mask
    send_word(frame_word(2, 4, 3, 8'h02));
    send_bits(64'b0, 1);
    send_word(frame_word(2, 4, 3, 8'h02));
    send_bits(64'b01, 2);
    send_bits(64'b101, 3);
    send_bits(64'b011, 3);
    // trailing bit after the frame closed: dropped
    send_word(bit_word(1'b1));
    drain_results();

    while (words_sent < 170) begin
      random_frame();
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    drain_results();
    repeat (32) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("ms_mask_parser_core_test: clean");
    end else begin
      $display("ms_mask_parser_core_test: errors");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("ms_mask_parser_core_test: errors");
    $finish;
  end

endmodule
